FILE: hdl/chunked_image_receiver_assert.svh
// ----------------------------------------------------------------------------
// chunked image receiver assertion macros
// shared forms for the concurrent checks on the receiver ports
// ----------------------------------------------------------------------------
`ifndef CHUNKED_IMAGE_RECEIVER_ASSERT_SVH
`define CHUNKED_IMAGE_RECEIVER_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define CIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is high
`define CIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_pkg
// shared types, codes and constants of the chunked image receiver
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int unsigned IMAGE_BYTES_DEF = 65536;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_OPCODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_OPCODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_OPCODE  = 2'd2;

  localparam logic [7:0] INIT_OPCODE_RST = 8'd1;
  localparam logic [7:0] DATA_OPCODE_RST = 8'd2;
  localparam logic [7:0] END_OPCODE_RST  = 8'd3;

  // result beat layout
  localparam int OUT_DATA_W = 96;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RX,
    MODE_COMPLETE,
    MODE_ERROR
  } mode_t;

  typedef enum logic [1:0] {
    REPLY_NONE,
    REPLY_ACK,
    REPLY_ERROR
  } reply_t;

  typedef enum logic {
    KIND_WRITE,
    KIND_VERDICT
  } kind_t;

  typedef struct packed {
    logic [7:0] init_opcode;
    logic [7:0] data_opcode;
    logic [7:0] end_opcode;
  } cfg_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [15:0] store_address;
    logic [7:0]  store_byte;
    reply_t      reply;
    logic [15:0] reply_index;
    mode_t       packet_status;
    logic [16:0] image_size;
    logic [31:0] total_crc;
    mode_t       parser_mode;
  } result_t;

endpackage

FILE: hdl/cir_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_crc
// one byte of reflected crc-32 update, lsb first
// ----------------------------------------------------------------------------
module cir_crc (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  logic [31:0] c;

  always_comb begin
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ cir_pkg::CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

FILE: hdl/cir_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_core
// packet parser state, chunk check and commit, and the result register
// ----------------------------------------------------------------------------
module cir_core #(
  parameter int unsigned IMAGE_BYTES = cir_pkg::IMAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cir_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              take,
  output logic              res_valid,
  input  logic              res_ready,
  output cir_pkg::result_t  res
);

  localparam int OFS_W = $clog2(IMAGE_BYTES + 1);
  localparam logic [OFS_W:0] LIMIT = (OFS_W + 1)'(IMAGE_BYTES);

  // persistent state
  cir_pkg::mode_t   mode, mode_next;
  logic [OFS_W-1:0] write_offset, write_offset_next;
  logic [OFS_W-1:0] committed_size, committed_size_next;
  logic [31:0]      expected_crc, expected_crc_next;

  // per-packet state
  logic [8:0]  byte_position, byte_position_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [15:0] chunk_index, chunk_index_next;
  logic [7:0]  chunk_length, chunk_length_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] trailer_crc, trailer_crc_next;
  logic [31:0] init_crc_field, init_crc_field_next;

  logic [31:0]       crc_step;
  logic [8:0]        data_rel;
  logic [8:0]        trail_rel;
  logic              in_data;
  logic              in_trailer;
  logic [OFS_W:0]    addr;
  logic [OFS_W:0]    sum_len;
  logic [OFS_W+16:0] addr_wide;
  logic [OFS_W+16:0] size_wide;
  logic [9:0]        total;
  logic [9:0]        need_len;
  logic              short_pkt;
  logic              crc_ok;
  logic              write_hit;
  logic              produce;
  cir_pkg::reply_t   reply;
  cir_pkg::mode_t    status;
  cir_pkg::result_t  res_next;

  cir_crc u_crc (
    .crc_in  (running_crc),
    .data    (in_byte),
    .crc_out (crc_step)
  );

  always_comb begin
    mode_next           = mode;
    write_offset_next   = write_offset;
    committed_size_next = committed_size;
    expected_crc_next   = expected_crc;
    command_byte_next   = command_byte;
    chunk_index_next    = chunk_index;
    chunk_length_next   = chunk_length;
    init_crc_field_next = init_crc_field;
    trailer_crc_next    = trailer_crc;
    reply               = cir_pkg::REPLY_NONE;
    status              = cir_pkg::MODE_ERROR;

    data_rel   = byte_position - 9'd4;
    trail_rel  = data_rel - {1'b0, chunk_length};
    in_data    = (byte_position >= 9'd4) && (data_rel < {1'b0, chunk_length});
    in_trailer = (byte_position >= 9'd4) && !in_data && (trail_rel < 9'd4);

    // header bytes
    case (byte_position)
      9'd0: command_byte_next = in_byte;
      9'd1: chunk_index_next[7:0] = in_byte;
      9'd2: chunk_index_next[15:8] = in_byte;
      9'd3: chunk_length_next = in_byte;
      default: ;
    endcase

    if (in_data && (data_rel < 9'd4)) begin
      init_crc_field_next = init_crc_field | ({24'd0, in_byte} << {data_rel[1:0], 3'b000});
    end
    if (in_trailer) begin
      trailer_crc_next = trailer_crc | ({24'd0, in_byte} << {trail_rel[1:0], 3'b000});
    end
    running_crc_next = in_data ? crc_step : running_crc;

    addr      = {1'b0, write_offset} + (OFS_W + 1)'(data_rel[7:0]);
    write_hit = in_data && !in_last && (mode == cir_pkg::MODE_RX)
                && (command_byte == cfg.data_opcode) && (addr < LIMIT);

    if (byte_position != 9'd511) begin
      byte_position_next = byte_position + 9'd1;
    end else begin
      byte_position_next = byte_position;
    end

    // verdict on the final byte
    total     = {1'b0, byte_position} + 10'd1;
    need_len  = 10'd8 + {2'd0, chunk_length_next};
    short_pkt = (total < 10'd8) || (total < need_len);
    crc_ok    = (~running_crc_next) == trailer_crc_next;
    sum_len   = {1'b0, write_offset} + (OFS_W + 1)'(chunk_length_next);

    if (in_last) begin
      if (short_pkt) begin
        status = cir_pkg::MODE_ERROR;
      end else if (command_byte_next == cfg.init_opcode) begin
        if (chunk_length_next >= 8'd4) begin
          expected_crc_next = init_crc_field_next;
        end
        write_offset_next   = '0;
        committed_size_next = '0;
        mode_next           = cir_pkg::MODE_RX;
        reply               = cir_pkg::REPLY_ACK;
        status              = cir_pkg::MODE_RX;
      end else if (command_byte_next == cfg.data_opcode) begin
        if (mode != cir_pkg::MODE_RX) begin
          status = cir_pkg::MODE_ERROR;
        end else if (!crc_ok) begin
          reply  = cir_pkg::REPLY_ERROR;
          status = cir_pkg::MODE_ERROR;
        end else if (sum_len <= LIMIT) begin
          write_offset_next = sum_len[OFS_W-1:0];
          reply             = cir_pkg::REPLY_ACK;
          status            = mode;
        end else begin
          mode_next = cir_pkg::MODE_ERROR;
          status    = cir_pkg::MODE_ERROR;
        end
      end else if (command_byte_next == cfg.end_opcode) begin
        committed_size_next = write_offset;
        mode_next           = cir_pkg::MODE_COMPLETE;
        status              = cir_pkg::MODE_COMPLETE;
      end

      // packet state back to its idle values
      byte_position_next  = '0;
      command_byte_next   = '0;
      chunk_index_next    = '0;
      chunk_length_next   = '0;
      running_crc_next    = '1;
      trailer_crc_next    = '0;
      init_crc_field_next = '0;
    end

    addr_wide = {16'd0, addr};
    size_wide = {17'd0, committed_size_next};

    res_next.image_size  = size_wide[16:0];
    res_next.total_crc   = expected_crc_next;
    res_next.parser_mode = mode_next;
    if (in_last) begin
      res_next.result_kind   = cir_pkg::KIND_VERDICT;
      res_next.store_address = '0;
      res_next.store_byte    = '0;
      res_next.reply         = reply;
      res_next.reply_index   = (reply != cir_pkg::REPLY_NONE) ? chunk_index : '0;
      res_next.packet_status = status;
    end else begin
      res_next.result_kind   = cir_pkg::KIND_WRITE;
      res_next.store_address = addr_wide[15:0];
      res_next.store_byte    = in_byte;
      res_next.reply         = cir_pkg::REPLY_NONE;
      res_next.reply_index   = '0;
      res_next.packet_status = cir_pkg::MODE_IDLE;
    end

    produce = in_last || write_hit;
    take    = in_valid && (!produce || !res_valid || res_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= cir_pkg::MODE_IDLE;
      write_offset   <= '0;
      committed_size <= '0;
      expected_crc   <= '0;
      byte_position  <= '0;
      command_byte   <= '0;
      chunk_index    <= '0;
      chunk_length   <= '0;
      running_crc    <= '1;
      trailer_crc    <= '0;
      init_crc_field <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (take) begin
        mode           <= mode_next;
        write_offset   <= write_offset_next;
        committed_size <= committed_size_next;
        expected_crc   <= expected_crc_next;
        byte_position  <= byte_position_next;
        command_byte   <= command_byte_next;
        chunk_index    <= chunk_index_next;
        chunk_length   <= chunk_length_next;
        running_crc    <= running_crc_next;
        trailer_crc    <= trailer_crc_next;
        init_crc_field <= init_crc_field_next;
      end
      if (take && produce) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      res <= res_next;
    end
  end

endmodule

FILE: hdl/chunked_image_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_image_receiver
// byte-serial receiver for a chunked image upload with crc-checked commits
// ----------------------------------------------------------------------------
// Packet bytes enter one beat per clock on the slave stream, tlast on the
// final byte. A packet is a command byte, a little-endian 16-bit index, a
// length L, L data bytes and a little-endian crc-32 of the data. Every data
// byte of a chunk that may land in the image store leaves at once as a
// tentative write beat (tuser 0); the final byte of each packet yields one
// verdict beat (tuser 1) carrying the reply, status and the committed state.
// Throughput is one byte per clock while the result side keeps up; an input
// beat passes the input register and then the result register on its way to
// a result beat. The rate is set by the per-byte loop through the parser
// state, a combinational byte-wide crc-32 update plus the header, trailer and
// commit compares. While a result beat waits, bytes that yield no result still
// pass through; the first byte that needs a result slot holds in the input
// register and the slave side stalls until the waiting beat is taken.
// Opcodes are written through the cfg port, which is always ready, and
// should only be changed while no packet is in flight.
module chunked_image_receiver #(
  parameter int unsigned IMAGE_BYTES = cir_pkg::IMAGE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // packet byte stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // packet_byte
  input  logic                            s_axis_tlast,  // packet_end
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // store_address[15:0], store_byte[23:16], reply[25:24], reply_index[41:26],
  // packet_status[43:42], image_size[60:44], total_crc[92:61],
  // parser_mode[94:93], zero pad[95]
  output logic [cir_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser,  // result_kind
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);

  cir_pkg::cfg_t    cfg;
  cir_pkg::result_t res;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       take;

  // opcode registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_opcode <= cir_pkg::INIT_OPCODE_RST;
      cfg.data_opcode <= cir_pkg::DATA_OPCODE_RST;
      cfg.end_opcode  <= cir_pkg::END_OPCODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cir_pkg::CFG_INIT_OPCODE: cfg.init_opcode <= cfg_data;
        cir_pkg::CFG_DATA_OPCODE: cfg.data_opcode <= cfg_data;
        cir_pkg::CFG_END_OPCODE:  cfg.end_opcode  <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // the slot frees when the core consumes it, so a beat can land every clock
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  cir_core #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .take      (take),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // pack the result beat, first field lowest
  assign m_axis_tuser = res.result_kind;
  assign m_axis_tdata = {1'b0,
                         res.parser_mode,
                         res.total_crc,
                         res.image_size,
                         res.packet_status,
                         res.reply_index,
                         res.reply,
                         res.store_byte,
                         res.store_address};

endmodule

FILE: hdl/cir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_checker
// port-level checks on the result stream of the receiver
// ----------------------------------------------------------------------------
`include "chunked_image_receiver_assert.svh"

module cir_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cir_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  logic [cir_pkg::OUT_DATA_W:0] beat;
  logic [1:0]                   reply_f;
  logic [15:0]                  index_f;
  logic [1:0]                   status_f;
  logic [1:0]                   mode_f;
  logic                         stalled;
  logic                         write_beat;
  logic                         verdict_beat;
  logic                         ack_beat;
  logic                         write_clean;
  logic                         ack_rx;
  logic                         reply_ok;

  assign beat     = {m_axis_tuser, m_axis_tdata};
  assign reply_f  = m_axis_tdata[25:24];
  assign index_f  = m_axis_tdata[41:26];
  assign status_f = m_axis_tdata[43:42];
  assign mode_f   = m_axis_tdata[94:93];

  assign stalled      = m_axis_tvalid && !m_axis_tready;
  assign write_beat   = m_axis_tvalid && !m_axis_tuser;
  assign verdict_beat = m_axis_tvalid && m_axis_tuser;
  assign ack_beat     = verdict_beat && (reply_f == cir_pkg::REPLY_ACK);

  assign write_clean = (reply_f == cir_pkg::REPLY_NONE) && (status_f == cir_pkg::MODE_IDLE);
  assign ack_rx      = (status_f == cir_pkg::MODE_RX) && (mode_f == cir_pkg::MODE_RX);
  assign reply_ok    = (reply_f != cir_pkg::REPLY_NONE || index_f == 16'd0)
                       && (reply_f != cir_pkg::REPLY_ERROR || status_f == cir_pkg::MODE_ERROR)
                       && (reply_f <= cir_pkg::REPLY_ERROR);

  // a stalled beat holds
  `CIR_ASSERT_NEXT(a_hold, clk, rst, stalled, m_axis_tvalid && $stable(beat), "stalled beat changed")

  // write beats carry no reply and idle status
  `CIR_ASSERT_NOW(a_write_clean, clk, rst, write_beat, write_clean, "write beat with verdict fields")

  // an acknowledge always leaves the parser receiving
  `CIR_ASSERT_NOW(a_ack_rx, clk, rst, ack_beat, ack_rx, "ack without receiving status")

  // no reply means no echoed index, an error reply means error status, and no undefined reply code appears
  `CIR_ASSERT_NOW(a_reply_index, clk, rst, verdict_beat, reply_ok, "inconsistent verdict reply")

endmodule

bind chunked_image_receiver cir_checker u_cir_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: sim/cir_upload_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_upload_scoreboard_pkg
// upload tracker and result scoreboard for the chunked image receiver bench
// ----------------------------------------------------------------------------
package cir_upload_scoreboard_pkg;
  import cir_pkg::*;

  class upload_scoreboard;
    // opcodes as last written
    logic [7:0]  init_op;
    logic [7:0]  data_op;
    logic [7:0]  end_op;
    // upload progress
    mode_t       mode;
    int          write_offset;
    logic [16:0] committed_size;
    logic [31:0] image_crc;
    // per-packet parse state
    int          byte_pos;
    logic [7:0]  cmd_byte;
    logic [15:0] chunk_idx;
    int          chunk_len;
    logic [31:0] running_crc;
    logic [31:0] trailer_crc;
    logic [31:0] init_crc_field;

    result_t     pending[$];
    int          mismatches;

    function new();
      init_op = INIT_OPCODE_RST;
      data_op = DATA_OPCODE_RST;
      end_op = END_OPCODE_RST;
      mode = MODE_IDLE;
      write_offset = 0;
      committed_size = '0;
      image_crc = '0;
      mismatches = 0;
      clear_packet();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void clear_packet();
      byte_pos = 0;
      cmd_byte = '0;
      chunk_idx = '0;
      chunk_len = 0;
      running_crc = '1;
      trailer_crc = '0;
      init_crc_field = '0;
    endfunction

    function void set_opcode(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_INIT_OPCODE: init_op = val;
        CFG_DATA_OPCODE: data_op = val;
        CFG_END_OPCODE:  end_op = val;
        default: ;
      endcase
    endfunction

    function void push_result(kind_t kind, logic [15:0] addr, logic [7:0] data,
                              reply_t rep, logic [15:0] idx, mode_t status);
      result_t r;
      r.result_kind = kind;
      r.store_address = addr;
      r.store_byte = data;
      r.reply = rep;
      r.reply_index = idx;
      r.packet_status = status;
      r.image_size = committed_size;
      r.total_crc = image_crc;
      r.parser_mode = mode;
      pending.push_back(r);
    endfunction

    // one accepted packet byte
    function void note_byte(logic [7:0] b, logic last);
      int pos;
      int k;
      int addr;
      int total;
      reply_t rep;
      mode_t status;
      pos = byte_pos;
      k = pos - 4;
      if (pos == 0) cmd_byte = b;
      else if (pos == 1) chunk_idx[7:0] = b;
      else if (pos == 2) chunk_idx[15:8] = b;
      else if (pos == 3) chunk_len = b;
      else if (k < chunk_len) begin
        addr = write_offset + k;
        running_crc = crc_step(running_crc, b);
        if (k < 4) init_crc_field[8*k +: 8] = b;
        if (!last && mode == MODE_RX && cmd_byte == data_op && addr < IMAGE_BYTES_DEF)
          push_result(KIND_WRITE, addr[15:0], b, REPLY_NONE, 16'd0, MODE_IDLE);
      end else if (k - chunk_len < 4) begin
        trailer_crc[8*(k-chunk_len) +: 8] = b;
      end
      if (byte_pos < 511) byte_pos++;
      if (!last) return;

      total = pos + 1;
      rep = REPLY_NONE;
      status = MODE_ERROR;
      if (total < 8 || total < 8 + chunk_len) begin
        // short packet: error status, nothing changes
      end else if (cmd_byte == init_op) begin
        if (chunk_len >= 4) image_crc = init_crc_field;
        write_offset = 0;
        committed_size = '0;
        mode = MODE_RX;
        rep = REPLY_ACK;
        status = mode;
      end else if (cmd_byte == data_op) begin
        if (mode != MODE_RX) begin
          status = MODE_ERROR;
        end else if (~running_crc != trailer_crc) begin
          rep = REPLY_ERROR;
        end else if (write_offset + chunk_len <= IMAGE_BYTES_DEF) begin
          write_offset += chunk_len;
          rep = REPLY_ACK;
          status = mode;
        end else begin
          mode = MODE_ERROR;
        end
      end else if (cmd_byte == end_op) begin
        committed_size = write_offset[16:0];
        mode = MODE_COMPLETE;
        status = mode;
      end
      push_result(KIND_VERDICT, 16'd0, 8'd0, rep,
                  (rep != REPLY_NONE) ? chunk_idx : 16'd0, status);
      clear_packet();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        mismatches++;
        $display("%0t: %s expected %h actual %h", $time, name, want, seen);
      end
    endfunction

    // one accepted result beat
    function void check_beat(logic [OUT_DATA_W-1:0] data, logic user);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none actual %h kind %0d",
                 $time, data, user);
        return;
      end
      want = pending.pop_front();
      compare_field("result_kind", want.result_kind, user);
      compare_field("store_address", want.store_address, data[15:0]);
      compare_field("store_byte", want.store_byte, data[23:16]);
      compare_field("reply", want.reply, data[25:24]);
      compare_field("reply_index", want.reply_index, data[41:26]);
      compare_field("packet_status", want.packet_status, data[43:42]);
      compare_field("image_size", want.image_size, data[60:44]);
      compare_field("total_crc", want.total_crc, data[92:61]);
      compare_field("parser_mode", want.parser_mode, data[94:93]);
    endfunction
  endclass

endpackage

FILE: sim/chunked_image_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_image_receiver_test
// self-checking bench for the chunked image receiver
// ----------------------------------------------------------------------------
// Packets are built here with real crc-32 trailers and streamed byte by byte;
// every accepted byte is fed to an upload tracker that predicts the store
// write and verdict beats, and every result beat is compared field by field.
// A short directed run covers idle, short, equal-opcode and long packets, and
// four random phases with different opcodes and idling finish the job.
module chunked_image_receiver_test;
  import cir_pkg::*;
  import cir_upload_scoreboard_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 12;        // two-stage pipe plus margin
  localparam int HOLD_CYCLES   = 300;       // long result hold-off
  localparam int PHASE_BYTES   = 265;
  localparam int TIMEOUT_NS    = 5_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [7:0]            cfg_data = '0;

  upload_scoreboard sb;

  // idling knobs, set per phase by the main sequence
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // hold-off requests: the receiver process owns the countdown
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic [7:0] pkt[$];     // packet under construction
  int         phase_bytes;

  // opcode sets and idling per random phase, extremes in the middle two
  logic [7:0] phase_init[4] = '{8'h01, 8'h00, 8'hFF, 8'hA5};
  logic [7:0] phase_data[4] = '{8'h02, 8'hFF, 8'h00, 8'h5A};
  logic [7:0] phase_end[4]  = '{8'h03, 8'h80, 8'h7F, 8'h3C};
  int         phase_send[4] = '{0, 70, 0, 36};
  int         phase_recv[4] = '{0, 0, 70, 36};

  chunked_image_receiver u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // beats are sampled mid-cycle, where nothing moves until the next edge
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
  end

  // one byte beat, with random gaps in front of it
  task automatic send_byte(logic [7:0] b, logic last);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_axis_tready;
      if (taken) sb.note_byte(b, last);
      @(posedge clk);
    end
    phase_bytes++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // header, random chunk data, crc-32 trailer (optionally spoilt), extra bytes
  function automatic void build_packet(logic [7:0] cmd, int len, bit good_crc, int extra);
    logic [31:0] crc;
    logic [15:0] idx;
    logic [7:0]  b;
    idx = 16'($urandom);
    crc = '1;
    pkt.delete();
    pkt.push_back(cmd);
    pkt.push_back(idx[7:0]);
    pkt.push_back(idx[15:8]);
    pkt.push_back(len[7:0]);
    repeat (len) begin
      b = 8'($urandom);
      crc = upload_scoreboard::crc_step(crc, b);
      pkt.push_back(b);
    end
    crc = ~crc;
    if (!good_crc) crc ^= 32'd1 << $urandom_range(31);
    for (int i = 0; i < 4; i++) pkt.push_back(crc[8*i +: 8]);
    repeat (extra) pkt.push_back(8'($urandom));
  endfunction

  // mostly small chunks, a few long ones so the length byte sees every bit
  function automatic int chunk_len_pick();
    int r;
    r = $urandom_range(99);
    if (r < 2) return $urandom_range(255, 128);
    if (r < 10) return $urandom_range(40, 17);
    return $urandom_range(16);
  endfunction

  // sender pause: everything expected has come out, then the pipe settles
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three opcode registers back to back, valid dropped once at the end
  task automatic write_opcodes(logic [7:0] init_val, logic [7:0] data_val,
                               logic [7:0] end_val);
    logic [CFG_IDX_W-1:0] regs[3];
    logic [7:0]           vals[3];
    bit                   taken;
    regs = '{CFG_INIT_OPCODE, CFG_DATA_OPCODE, CFG_END_OPCODE};
    vals = '{init_val, data_val, end_val};
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data <= vals[r];
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        taken = cfg_ready;
        if (taken) sb.set_opcode(regs[r], vals[r]);
        @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // one random upload session, or one stray packet
  task automatic random_traffic();
    int         pick;
    int         cut;
    logic [7:0] cmd;
    pick = $urandom_range(99);
    if (pick < 60) begin
      // well-formed session: init, a few chunks, usually an end
      build_packet(sb.init_op, $urandom_range(8), 1'b1, 0);
      send_packet();
      repeat ($urandom_range(5, 1)) begin
        build_packet(sb.data_op, chunk_len_pick(), $urandom_range(99) < 85,
                     ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0);
        send_packet();
      end
      if ($urandom_range(99) < 80) begin
        build_packet(sb.end_op, $urandom_range(3), 1'b1, 0);
        send_packet();
      end
    end else begin
      case ($urandom_range(5))
        0: begin
          // command byte matching no opcode
          do cmd = 8'($urandom);
          while (cmd == sb.init_op || cmd == sb.data_op || cmd == sb.end_op);
          build_packet(cmd, $urandom_range(12), 1'b1, 0);
        end
        1: begin
          // packet cut short somewhere before its trailer ends
          cmd = $urandom_range(1) ? sb.data_op : sb.init_op;
          build_packet(cmd, $urandom_range(16), 1'b1, 0);
          cut = $urandom_range(pkt.size() - 1, 1);
          while (pkt.size() > cut) void'(pkt.pop_back());
        end
        2: build_packet(sb.data_op, chunk_len_pick(), 1'b1, 0);
        3: build_packet(sb.end_op, $urandom_range(4), 1'b1, 0);
        4: begin
          // raw garbage
          pkt.delete();
          repeat ($urandom_range(12, 1)) pkt.push_back(8'($urandom));
        end
        default: build_packet(sb.data_op, chunk_len_pick(), 1'b0, 0);
      endcase
      send_packet();
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: data and end before any init, lone all-ones byte, null command
    build_packet(sb.data_op, 0, 1'b1, 0);
    send_packet();
    pkt = '{8'hFF};
    send_packet();
    build_packet(sb.end_op, 0, 1'b1, 0);
    send_packet();
    build_packet(8'h00, 0, 1'b1, 0);
    send_packet();
    // init latching the image crc, one good chunk, one with a bad crc
    build_packet(sb.init_op, 4, 1'b1, 0);
    send_packet();
    build_packet(sb.data_op, 1, 1'b1, 0);
    send_packet();
    build_packet(sb.data_op, 1, 1'b0, 0);
    send_packet();

    // equal opcodes: init wins over data and end
    wait_drained();
    write_opcodes(8'h00, 8'h00, 8'h00);
    build_packet(8'h00, 0, 1'b1, 0);
    send_packet();
    // data wins over end; then a packet long enough to pin the byte counter
    wait_drained();
    write_opcodes(8'hFF, 8'h00, 8'h00);
    build_packet(8'hFF, 0, 1'b1, 0);
    send_packet();
    build_packet(8'h00, 3, 1'b1, 0);
    send_packet();
    build_packet(8'h00, 255, 1'b1, 300);
    send_packet();

    // random phases, each with its own opcodes and idling
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_opcodes(phase_init[ph], phase_data[ph], phase_end[ph]);
      send_idle_pct = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      phase_bytes = 0;
      // first phase: results held back while bytes keep coming
      if (ph == 0) hold_asks++;
      while (phase_bytes < PHASE_BYTES) random_traffic();
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
